// ----- rtl/usage_counter_hash_table_macros.svh -----
// Assertion helpers used by uch_back.
`ifndef USAGE_COUNTER_HASH_TABLE_MACROS_SVH
`define USAGE_COUNTER_HASH_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UCH_ASSERT_HOLDS(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UCH_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/uch_pkg.sv -----
`default_nettype none
package uch_pkg;

   typedef enum logic [1:0] {
      OP_TRACK   = 2'd0,
      OP_UNTRACK = 2'd1,
      OP_RECORD  = 2'd2,
      OP_GET     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_MISSING = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      MARK_EMPTY = 2'd0,
      MARK_LIVE  = 2'd1,
      MARK_DEAD  = 2'd2
   } mark_type;

   typedef struct packed {
      op_type      op;
      logic [63:0] record_id;
      logic [63:0] time_ms;
   } job_type;

   localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
   localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;
   localparam logic [31:0] COUNT_MAX = 32'hFFFFFFFF;

endpackage
`default_nettype wire

// ----- rtl/usage_counter_hash_table.sv -----
// Usage counter hash table: ids are tracked, untracked, counted and read back.
// Request words arrive on req_valid/req_ready with req_op, req_record_id and
// req_time_ms; each request yields exactly one response word on
// rsp_valid/rsp_ready, in request order, carrying status, the entry's count
// and time (get only), and the live entry count and recall total after it.
// csr_wr_en/csr_wr_data set the live limit; write it only while idle.
// A front end hashes each id with one shared 32x32 multiplier and a
// byte-serial modulo. A two-word queue feeds the back end, which probes
// one slot per cycle from the home slot through table memories with one
// read and one write port each. The response is registered when the probe
// ends. Front and back overlap: the front end hashes the next request while
// the back end probes. After reset a clearing pass marks every slot empty;
// req_ready stays low during that pass. A stalled receiver holds the
// response register; the back end then waits while the queue and front end
// keep taking words until the queue is full.
`default_nettype none
module usage_counter_hash_table #(
   parameter int SLOTS = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_op,
   input  wire logic [63:0] req_record_id,
   input  wire logic [63:0] req_time_ms,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [31:0]      rsp_recall_count,
   output logic [63:0]      rsp_last_recall_ms,
   output logic [8:0]       rsp_live_entries,
   output logic [63:0]      rsp_total_recalls,
   input  wire logic        csr_wr_en,
   input  wire logic [8:0]  csr_wr_data
);
   import uch_pkg::*;

   localparam int IW = $clog2(SLOTS);
   localparam int QW = $bits(job_type) + IW;

   logic          accept_en, q_full, q_push, q_pop, q_valid;
   job_type       f_job, b_job;
   logic [IW-1:0] f_home, b_home;
   logic [QW-1:0] q_out;

   uch_front #(.SLOTS(SLOTS), .IW(IW)) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (op_type'(req_op)),
      .req_record_id (req_record_id),
      .req_time_ms   (req_time_ms),
      .accept_en     (accept_en),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_job         (f_job),
      .q_home        (f_home)
   );

   uch_queue #(.W(QW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({f_job, f_home}),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (q_out)
   );

   assign b_job  = q_out[QW-1:IW];
   assign b_home = q_out[IW-1:0];

   uch_back #(.SLOTS(SLOTS), .IW(IW)) u_back (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .q_valid            (q_valid),
      .q_job              (b_job),
      .q_home             (b_home),
      .q_pop              (q_pop),
      .accept_en          (accept_en),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_recall_count   (rsp_recall_count),
      .rsp_last_recall_ms (rsp_last_recall_ms),
      .rsp_live_entries   (rsp_live_entries),
      .rsp_total_recalls  (rsp_total_recalls)
   );

endmodule
`default_nettype wire

// ----- rtl/uch_front.sv -----
`default_nettype none
module uch_front #(
   parameter int SLOTS = 256,
   parameter int IW    = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire uch_pkg::op_type  req_op,
   input  wire logic [63:0]      req_record_id,
   input  wire logic [63:0]      req_time_ms,
   input  wire logic             accept_en,
   input  wire logic             q_full,
   output logic                  q_push,
   output uch_pkg::job_type      q_job,
   output logic [IW-1:0]         q_home
);
   import uch_pkg::*;

   localparam int RW = IW + 8;

   typedef enum logic [3:0] {
      F_IDLE = 4'b0001,
      F_MUL  = 4'b0010,
      F_MOD  = 4'b0100,
      F_PUSH = 4'b1000
   } fstate_type;

   fstate_type    state_ff, state_in;
   job_type       job_ff, job_in;
   logic [63:0]   x_ff, x_in;
   logic [63:0]   acc_ff, acc_in;
   logic [1:0]    step_ff, step_in;
   logic          pass_ff, pass_in;
   logic [2:0]    dig_ff, dig_in;
   logic [IW-1:0] r_ff, r_in;
   logic [31:0]   ma, mb;
   logic [63:0]   prod, kc, sum;
   logic [RW-1:0] t;

   assign req_ready = (state_ff == F_IDLE) && accept_en;
   assign q_push    = (state_ff == F_PUSH) && !q_full;
   assign q_job     = job_ff;
   assign q_home    = r_ff;

   assign kc   = pass_ff ? MIX_C2 : MIX_C1;
   assign ma   = (step_ff == 2'd2) ? x_ff[63:32] : x_ff[31:0];
   assign mb   = (step_ff == 2'd1) ? kc[63:32] : kc[31:0];
   assign prod = {32'd0, ma} * {32'd0, mb};
   assign sum  = (step_ff == 2'd0) ? prod : acc_ff + {prod[31:0], 32'd0};

   always_comb begin
      t = {r_ff, x_ff[63:56]};
      for (int j = 7; j >= 0; j--) begin
         if (t >= (RW'(SLOTS) << j)) begin
            t = t - (RW'(SLOTS) << j);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      x_in     = x_ff;
      acc_in   = acc_ff;
      step_in  = step_ff;
      pass_in  = pass_ff;
      dig_in   = dig_ff;
      r_in     = r_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (req_valid && req_ready) begin
               job_in   = '{op: req_op, record_id: req_record_id, time_ms: req_time_ms};
               x_in     = req_record_id ^ (req_record_id >> 33);
               step_in  = 2'd0;
               pass_in  = 1'b0;
               state_in = F_MUL;
            end
         end
         F_MUL: begin
            acc_in = sum;
            if (step_ff == 2'd2) begin
               x_in    = sum ^ (sum >> 33);
               step_in = 2'd0;
               if (!pass_ff) begin
                  pass_in = 1'b1;
               end else begin
                  dig_in   = 3'd0;
                  r_in     = '0;
                  state_in = F_MOD;
               end
            end else begin
               step_in = step_ff + 2'd1;
            end
         end
         F_MOD: begin
            r_in   = t[IW-1:0];
            x_in   = x_ff << 8;
            dig_in = dig_ff + 3'd1;
            if (dig_ff == 3'd7) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!q_full) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      job_ff  <= job_in;
      x_ff    <= x_in;
      acc_ff  <= acc_in;
      step_ff <= step_in;
      pass_ff <= pass_in;
      dig_ff  <= dig_in;
      r_ff    <= r_in;
   end

endmodule
`default_nettype wire

// ----- rtl/uch_queue.sv -----
`default_nettype none
module uch_queue #(
   parameter int W = 8
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire logic [W-1:0] push_data,
   output logic              full,
   input  wire logic         pop,
   output logic              valid,
   output logic [W-1:0]      pop_data
);
   logic [W-1:0] ent_ff [2];
   logic         wr_ff, rd_ff;
   logic [1:0]   cnt_ff;
   logic         do_push, do_pop;

   assign full     = (cnt_ff == 2'd2);
   assign valid    = (cnt_ff != 2'd0);
   assign pop_data = ent_ff[rd_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ff <= !wr_ff;
         end
         if (do_pop) begin
            rd_ff <= !rd_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
      if (do_push) begin
         ent_ff[wr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/uch_back.sv -----
`default_nettype none
`include "usage_counter_hash_table_macros.svh"
module uch_back #(
   parameter int SLOTS = 256,
   parameter int IW    = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_wr_en,
   input  wire logic [8:0]       csr_wr_data,
   input  wire logic             q_valid,
   input  wire uch_pkg::job_type q_job,
   input  wire logic [IW-1:0]    q_home,
   output logic                  q_pop,
   output logic                  accept_en,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [1:0]            rsp_status,
   output logic [31:0]           rsp_recall_count,
   output logic [63:0]           rsp_last_recall_ms,
   output logic [8:0]            rsp_live_entries,
   output logic [63:0]           rsp_total_recalls
);
   import uch_pkg::*;

   typedef enum logic [2:0] {
      B_CLEAR = 3'b001,
      B_IDLE  = 3'b010,
      B_PROBE = 3'b100
   } bstate_type;

   logic [1:0]  mark_mem [SLOTS];
   logic [63:0] key_mem  [SLOTS];
   logic [31:0] cnt_mem  [SLOTS];
   logic [63:0] tim_mem  [SLOTS];
   logic [1:0]  mark_q;
   logic [63:0] key_q;
   logic [31:0] cnt_q;
   logic [63:0] tim_q;

   bstate_type    state_ff, state_in;
   logic [IW-1:0] clr_ff, clr_in;
   job_type       job_ff, job_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [IW-1:0] n_ff, n_in;
   logic          dead_ff, dead_in;
   logic [IW-1:0] dead_idx_ff, dead_idx_in;
   logic [8:0]    live_ff, live_in;
   logic [63:0]   sum_ff, sum_in;
   logic [8:0]    limit_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    status_ff, status_in;
   logic [31:0]   cnt_o_ff, cnt_o_in;
   logic [63:0]   tim_o_ff, tim_o_in;

   logic [IW-1:0] nxt_idx, rd_addr, place, wa;
   logic          hit, empty, last, dead_here, done, ok, out_free, fin, adv;
   logic          mark_we, key_we, cnt_we, tim_we;
   logic [1:0]    mark_wd;
   logic [IW-1:0] mark_wa;
   logic [31:0]   cnt_wd;
   logic [63:0]   tim_wd;

   assign accept_en = (state_ff != B_CLEAR);
   assign q_pop     = (state_ff == B_IDLE) && q_valid;

   assign nxt_idx   = (idx_ff == IW'(SLOTS - 1)) ? '0 : idx_ff + 1'b1;
   assign hit       = (mark_q == MARK_LIVE) && (key_q == job_ff.record_id);
   assign empty     = (mark_q == MARK_EMPTY);
   assign dead_here = (mark_q == MARK_DEAD);
   assign last      = (n_ff == IW'(SLOTS - 1));
   assign done      = hit || empty || last;
   assign ok        = empty || dead_ff || dead_here;
   assign place     = dead_ff ? dead_idx_ff : idx_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fin       = (state_ff == B_PROBE) && done && out_free;
   assign adv       = (state_ff == B_PROBE) && !done;

   always_comb begin
      if (state_ff == B_IDLE) begin
         rd_addr = q_home;
      end else if (adv) begin
         rd_addr = nxt_idx;
      end else begin
         rd_addr = idx_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      job_in       = job_ff;
      idx_in       = idx_ff;
      n_in         = n_ff;
      dead_in      = dead_ff;
      dead_idx_in  = dead_idx_ff;
      live_in      = live_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      cnt_o_in     = cnt_o_ff;
      tim_o_in     = tim_o_ff;
      mark_we      = 1'b0;
      mark_wa      = idx_ff;
      mark_wd      = MARK_EMPTY;
      key_we       = 1'b0;
      cnt_we       = 1'b0;
      tim_we       = 1'b0;
      wa           = idx_ff;
      cnt_wd       = '0;
      tim_wd       = '0;
      unique case (state_ff)
         B_CLEAR: begin
            mark_we = 1'b1;
            mark_wa = clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == IW'(SLOTS - 1)) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (q_valid) begin
               job_in   = q_job;
               idx_in   = q_home;
               n_in     = '0;
               dead_in  = 1'b0;
               state_in = B_PROBE;
            end
         end
         B_PROBE: begin
            if (adv) begin
               idx_in = nxt_idx;
               n_in   = n_ff + 1'b1;
               if (dead_here && !dead_ff) begin
                  dead_in     = 1'b1;
                  dead_idx_in = idx_ff;
               end
            end
            if (fin) begin
               status_in = ST_OK;
               cnt_o_in  = '0;
               tim_o_in  = '0;
               case (job_ff.op)
                  OP_TRACK: begin
                     if (!hit) begin
                        if (live_ff >= limit_ff || !ok) begin
                           status_in = ST_FULL;
                        end else begin
                           mark_we = 1'b1;
                           mark_wa = place;
                           mark_wd = MARK_LIVE;
                           key_we  = 1'b1;
                           cnt_we  = 1'b1;
                           tim_we  = 1'b1;
                           wa      = place;
                           live_in = live_ff + 9'd1;
                        end
                     end
                  end
                  OP_UNTRACK: begin
                     if (!hit) begin
                        status_in = ST_MISSING;
                     end else begin
                        mark_we = 1'b1;
                        mark_wd = MARK_DEAD;
                        sum_in  = sum_ff - {32'd0, cnt_q};
                        live_in = live_ff - 9'd1;
                     end
                  end
                  OP_RECORD: begin
                     if (!hit) begin
                        status_in = ST_MISSING;
                     end else begin
                        cnt_we = 1'b1;
                        tim_we = 1'b1;
                        cnt_wd = cnt_q + 32'd1;
                        tim_wd = job_ff.time_ms;
                        if (cnt_q == COUNT_MAX) begin
                           sum_in = sum_ff - {32'd0, COUNT_MAX};
                        end else begin
                           sum_in = sum_ff + 64'd1;
                        end
                     end
                  end
                  default: begin
                     if (!hit) begin
                        status_in = ST_MISSING;
                     end else begin
                        cnt_o_in = cnt_q;
                        tim_o_in = tim_q;
                     end
                  end
               endcase
               rsp_valid_in = 1'b1;
               state_in     = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      mark_q <= mark_mem[rd_addr];
      key_q  <= key_mem[rd_addr];
      cnt_q  <= cnt_mem[rd_addr];
      tim_q  <= tim_mem[rd_addr];
      if (mark_we) begin
         mark_mem[mark_wa] <= mark_wd;
      end
      if (key_we) begin
         key_mem[wa] <= job_ff.record_id;
      end
      if (cnt_we) begin
         cnt_mem[wa] <= cnt_wd;
      end
      if (tim_we) begin
         tim_mem[wa] <= tim_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_ff       <= '0;
         live_ff      <= '0;
         sum_ff       <= '0;
         limit_ff     <= 9'd192;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         live_ff      <= live_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
      job_ff      <= job_in;
      idx_ff      <= idx_in;
      n_ff        <= n_in;
      dead_ff     <= dead_in;
      dead_idx_ff <= dead_idx_in;
      status_ff   <= status_in;
      cnt_o_ff    <= cnt_o_in;
      tim_o_ff    <= tim_o_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_recall_count   = cnt_o_ff;
   assign rsp_last_recall_ms = tim_o_ff;
   assign rsp_live_entries   = live_ff;
   assign rsp_total_recalls  = sum_ff;

   `UCH_ASSERT_HOLDS(a_pop_has_word, clock, reset, q_pop, q_valid, "pop from empty queue")
   `UCH_ASSERT_HOLDS(a_quiet_in_clear, clock, reset, state_ff == B_CLEAR, !rsp_valid_ff && !q_pop, "activity during clearing pass")
   `UCH_ASSERT_NEXT(a_live_on_finish, clock, reset, !fin, $stable(live_ff) && $stable(sum_ff), "totals changed outside a finish")

endmodule
`default_nettype wire
